/* rtl/core/fages_pkg.sv */
package fages_pkg;

	// Glyph grid: 16 by 16 cells
	localparam int GRID_CELLS = 16;
	localparam int CELL_W = $clog2(GRID_CELLS);

	// Texture side register
	localparam int DEF_MAX_TEX_WIDTH = 1024;
	localparam int TEX_WIDTH_W = 11;
	localparam logic [TEX_WIDTH_W-1:0] TEX_WIDTH_RST = 11'd256;

	// Input beat: one alpha byte in raster order
	typedef struct packed {
		logic [7:0] alpha;
		logic       frame_start;
	} pixel_t;

	// Output beat: extent of one glyph cell
	typedef struct packed {
		logic [7:0] char_index;
		logic       empty_cell;
		logic [6:0] left_blank;
		logic [6:0] glyph_width;
		logic [6:0] glyph_height;
		logic [9:0] u_left;
		logic [9:0] v_top;
		logic       last;
	} result_t;

	// Controller to datapath commands
	typedef struct packed {
		logic              scan;
		logic              load;
		logic [CELL_W-1:0] idx;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic band_end;
	} sts_t;

endpackage

/* rtl/core/fages_stream_if.sv */
interface fages_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/fages_dp.sv */
module fages_dp #(
	parameter int MAX_TEX_WIDTH = fages_pkg::DEF_MAX_TEX_WIDTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [fages_pkg::TEX_WIDTH_W-1:0]  cfg_wdata,
	input  fages_pkg::pixel_t                  pix,
	input  fages_pkg::cmd_t                    cmd,
	output fages_pkg::sts_t                    sts,
	output fages_pkg::result_t                 res
);
	import fages_pkg::*;

	localparam int MAX_STEP = MAX_TEX_WIDTH / GRID_CELLS;
	localparam int SW = $clog2(MAX_STEP + 1);
	localparam int OW = (MAX_STEP > 1) ? $clog2(MAX_STEP) : 1;
	localparam int CW = $clog2(MAX_TEX_WIDTH);
	localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(GRID_CELLS - 1);

	// Cell side from the texture side: clamp, then drop the low four bits
	function automatic logic [SW-1:0] step_of(input logic [TEX_WIDTH_W-1:0] w);
		int unsigned v;
		v = 32'(w);
		if (v < GRID_CELLS)
			v = GRID_CELLS;
		if (v > MAX_TEX_WIDTH)
			v = MAX_TEX_WIDTH;
		return SW'(v / GRID_CELLS);
	endfunction

	localparam logic [SW-1:0] STEP_RST = step_of(TEX_WIDTH_RST);

	logic [SW-1:0]     step_q;
	logic [OW-1:0]     off_q;
	logic [CELL_W-1:0] cx_q;
	logic [OW-1:0]     roff_q;
	logic [CELL_W-1:0] band_q;
	logic [CW-1:0]     vbase_q;
	logic [GRID_CELLS-1:0] has_q;
	logic [OW-1:0]     first_q [GRID_CELLS];
	logic [OW-1:0]     last_q [GRID_CELLS];
	logic [CELL_W-1:0] dband_q;
	logic [CW-1:0]     dvbase_q;
	logic [CW-1:0]     ubase_q;
	result_t           res_q;

	logic                  fs;
	logic [CELL_W-1:0]     e_cx;
	logic [OW-1:0]         e_off;
	logic [OW-1:0]         e_roff;
	logic [CELL_W-1:0]     e_band;
	logic [CW-1:0]         e_vbase;
	logic [GRID_CELLS-1:0] e_has;
	logic                  off_last;
	logic                  roff_last;
	logic                  col_end;
	logic                  ink;
	logic [CELL_W-1:0]     rd_idx;
	logic [OW-1:0]         rd_first;
	logic [OW-1:0]         rd_last;
	logic                  rd_has;
	logic [OW-1:0]         new_first;
	logic [OW-1:0]         new_last;
	logic [OW-1:0]         blank;
	logic [OW:0]           wid;
	logic [CW-1:0]         u_sum;

	// A frame-start beat is scanned as pixel (0,0) of a cleared band
	always_comb begin
		fs      = pix.frame_start;
		e_cx    = fs ? '0 : cx_q;
		e_off   = fs ? '0 : off_q;
		e_roff  = fs ? '0 : roff_q;
		e_band  = fs ? '0 : band_q;
		e_vbase = fs ? '0 : vbase_q;
		e_has   = fs ? '0 : has_q;
	end

	// Position within cell and band
	assign off_last  = (SW'(e_off) == step_q - SW'(1));
	assign roff_last = (SW'(e_roff) == step_q - SW'(1));
	assign col_end   = off_last && (e_cx == LAST_CELL);
	assign sts.band_end = col_end && roff_last;

	// Single read port on the extent registers: scan cell or drain cell
	assign rd_idx   = cmd.scan ? e_cx : cmd.idx;
	assign rd_first = first_q[rd_idx];
	assign rd_last  = last_q[rd_idx];
	assign rd_has   = cmd.scan ? e_has[rd_idx] : has_q[rd_idx];

	// Widen the extent of the current cell
	assign ink       = (pix.alpha != 8'd0);
	assign new_first = (!rd_has || e_off < rd_first) ? e_off : rd_first;
	assign new_last  = (!rd_has || e_off > rd_last) ? e_off : rd_last;

	// Result fields of the drained cell
	assign blank = rd_has ? rd_first : '0;
	assign wid   = rd_has ? ((OW+1)'(rd_last) - (OW+1)'(rd_first) + (OW+1)'(1)) : '0;
	assign u_sum = ubase_q + CW'(blank);

	// Position counters, band state and texture side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= STEP_RST;
			off_q   <= '0;
			cx_q    <= '0;
			roff_q  <= '0;
			band_q  <= '0;
			vbase_q <= '0;
			has_q   <= '0;
		end else if (cfg_we) begin
			step_q  <= step_of(cfg_wdata);
			off_q   <= '0;
			cx_q    <= '0;
			roff_q  <= '0;
			band_q  <= '0;
			vbase_q <= '0;
			has_q   <= '0;
		end else if (cmd.scan) begin
			off_q  <= off_last ? '0 : e_off + OW'(1);
			cx_q   <= off_last ? e_cx + CELL_W'(1) : e_cx;
			roff_q <= col_end ? (roff_last ? '0 : e_roff + OW'(1)) : e_roff;
			if (sts.band_end) begin
				band_q  <= e_band + CELL_W'(1);
				vbase_q <= (e_band == LAST_CELL) ? '0 : e_vbase + CW'(step_q);
			end else begin
				band_q  <= e_band;
				vbase_q <= e_vbase;
			end
			has_q <= e_has | (ink ? (GRID_CELLS'(1) << e_cx) : '0);
		end else if (cmd.load && cmd.idx == LAST_CELL) begin
			has_q <= '0;
		end
	end

	// Extent registers: written only for inked pixels
	always_ff @(posedge clk) begin
		if (cmd.scan && ink) begin
			first_q[e_cx] <= new_first;
			last_q[e_cx]  <= new_last;
		end
	end

	// Hold the band position for the drain and step the cell base
	always_ff @(posedge clk) begin
		if (cmd.scan && sts.band_end) begin
			dband_q  <= e_band;
			dvbase_q <= e_vbase;
			ubase_q  <= '0;
		end else if (cmd.load) begin
			ubase_q <= ubase_q + CW'(step_q);
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_q.char_index   <= 8'({dband_q, cmd.idx});
			res_q.empty_cell   <= !rd_has;
			res_q.left_blank   <= 7'(blank);
			res_q.glyph_width  <= 7'(wid);
			res_q.glyph_height <= 7'(step_q);
			res_q.u_left       <= 10'(u_sum);
			res_q.v_top        <= 10'(dvbase_q);
			res_q.last         <= (cmd.idx == LAST_CELL);
		end
	end

	assign res = res_q;

endmodule

/* rtl/core/fages_ctrl.sv */
module fages_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            out_ready,
	input  fages_pkg::sts_t sts,
	output logic            in_ready,
	output logic            out_valid,
	output fages_pkg::cmd_t cmd
);
	import fages_pkg::*;

	localparam logic ST_SCAN  = 1'b0;
	localparam logic ST_DRAIN = 1'b1;
	localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(GRID_CELLS - 1);

	logic              state_q;
	logic [CELL_W-1:0] idx_q;
	logic              out_valid_q;

	// Take pixels while scanning; while draining, load a result whenever the output slot frees
	assign in_ready  = (state_q == ST_SCAN);
	assign cmd.scan  = in_valid && in_ready;
	assign cmd.load  = (state_q == ST_DRAIN) && (!out_valid_q || out_ready);
	assign cmd.idx   = idx_q;
	assign out_valid = out_valid_q;

	// Scan / drain sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SCAN;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_SCAN: begin
					if (cmd.scan && sts.band_end) begin
						state_q <= ST_DRAIN;
						idx_q   <= '0;
					end
				end
				ST_DRAIN: begin
					if (cmd.load) begin
						idx_q <= idx_q + CELL_W'(1);
						if (idx_q == LAST_CELL)
							state_q <= ST_SCAN;
					end
				end
				default: begin
					state_q <= ST_SCAN;
				end
			endcase
		end
	end

	// Output beat valid: set on load, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	a_band_end_drains: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan && sts.band_end |=> state_q == ST_DRAIN && idx_q == '0)
		else $error("band end did not start a drain");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !cmd.load)
		else $error("pending result overwritten");

	a_drain_ends: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && idx_q == LAST_CELL |=> state_q == ST_SCAN && out_valid_q)
		else $error("drain did not end after the last cell");

	a_no_scan_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !cmd.scan)
		else $error("pixel taken during drain");

endmodule

/* rtl/core/font_atlas_glyph_extent_scan.sv */
// Glyph extent scanner for a 16 by 16 bitmap font atlas. Alpha bytes enter
// on pix in raster order, one beat per cycle while scanning; frame_start on a
// beat restarts the position counters and discards any partial band. The
// cell side (step) is cfg_wdata clamped to 16..MAX_TEX_WIDTH, divided by 16;
// a write to cfg_we also restarts the scan. After the last pixel of each band
// of cells, pix.ready drops and the 16 cell results drain left to right from
// the per-cell extent registers through the output register, one per cycle
// while res.ready is high. Empty cells are flagged, not skipped.
module font_atlas_glyph_extent_scan #(
	parameter int MAX_TEX_WIDTH = fages_pkg::DEF_MAX_TEX_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [fages_pkg::TEX_WIDTH_W-1:0] cfg_wdata,
	fages_stream_if.sink                      pix,
	fages_stream_if.source                    res
);
	import fages_pkg::*;

	cmd_t    cmd;
	sts_t    sts;
	pixel_t  pix_data;
	result_t res_data;
	logic    in_ready;
	logic    out_valid;

	assign pix_data  = pix.data;
	assign pix.ready = in_ready;
	assign res.valid = out_valid;
	assign res.data  = res_data;

	// Sequencer
	fages_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pix.valid),
		.out_ready (res.ready),
		.sts       (sts),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	// Counters, extent registers and output register
	fages_dp #(
		.MAX_TEX_WIDTH (MAX_TEX_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.pix       (pix_data),
		.cmd       (cmd),
		.sts       (sts),
		.res       (res_data)
	);

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
	import fages_pkg::*;

	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned TAIL_CYCLES = 20;
	localparam int unsigned N_PATTERNS = 5;

	// Ink layouts for the cells of a generated band
	typedef enum int unsigned {
		PAT_EMPTY,
		PAT_LEFT,
		PAT_RIGHT,
		PAT_BOTH,
		PAT_SPARSE
	} cell_pat_e;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_we;
	logic [TEX_WIDTH_W-1:0] cfg_wdata;

	fages_stream_if #(.T(pixel_t))  pix_if ();
	fages_stream_if #(.T(result_t)) res_if ();

	font_atlas_glyph_extent_scan uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.pix      (pix_if),
		.res      (res_if)
	);

	always #5 clk = ~clk;

	// Scan state mirror; counters are kept wide as they touch the side before wrapping
	logic [TEX_WIDTH_W-1:0] model_tex_width;
	int unsigned            scan_col;
	int unsigned            scan_row;
	logic [5:0]             ink_first [GRID_CELLS];
	logic [5:0]             ink_last [GRID_CELLS];
	logic                   ink_seen [GRID_CELLS];
	result_t                extents_q [$];

	int unsigned fail_count = 0;
	int unsigned pixel_count = 0;
	int unsigned extent_count = 0;
	int unsigned width_writes = 0;
	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned hold_len = 0;
	int unsigned cur_step = 16;

	// Clamp the register to the legal range and round down to whole cells
	function automatic int unsigned side_for(logic [TEX_WIDTH_W-1:0] w);
		int unsigned s;
		s = w;
		if (s < GRID_CELLS)
			s = GRID_CELLS;
		if (s > DEF_MAX_TEX_WIDTH)
			s = DEF_MAX_TEX_WIDTH;
		return s - (s % GRID_CELLS);
	endfunction

	task automatic clear_band_extents();
		for (int c = 0; c < GRID_CELLS; c++) begin
			ink_first[c] = '1;
			ink_last[c] = '0;
			ink_seen[c] = 1'b0;
		end
	endtask

	task automatic restart_scan();
		scan_col = 0;
		scan_row = 0;
		clear_band_extents();
	endtask

	// Advance the scan by one pixel; queue a band of extents when it closes
	task automatic scan_pixel(input pixel_t p);
		int unsigned side;
		int unsigned step;
		int unsigned cx;
		int unsigned off;
		int unsigned band;
		int unsigned blank;
		int unsigned wid;
		result_t r;
		side = side_for(model_tex_width);
		step = side / GRID_CELLS;
		if (p.frame_start)
			restart_scan();
		if (scan_col >= side || scan_row >= side)
			restart_scan();
		cx = scan_col / step;
		off = scan_col % step;
		if (cx >= GRID_CELLS)
			cx = GRID_CELLS - 1;
		if (p.alpha != 8'd0) begin
			if (!ink_seen[cx] || off < ink_first[cx])
				ink_first[cx] = 6'(off);
			if (!ink_seen[cx] || off > ink_last[cx])
				ink_last[cx] = 6'(off);
			ink_seen[cx] = 1'b1;
		end
		scan_col++;
		if (scan_col < side)
			return;
		scan_col = 0;
		scan_row++;
		if (scan_row % step != 0)
			return;
		band = (scan_row - 1) / step;
		if (scan_row >= side)
			scan_row = 0;
		for (int c = 0; c < GRID_CELLS; c++) begin
			blank = 0;
			wid = 0;
			if (ink_seen[c]) begin
				blank = ink_first[c];
				wid = ink_last[c] - ink_first[c] + 1;
			end
			r.char_index = 8'(band * GRID_CELLS + c);
			r.empty_cell = !ink_seen[c];
			r.left_blank = 7'(blank);
			r.glyph_width = 7'(wid);
			r.glyph_height = 7'(step);
			r.u_left = 10'(c * step + blank);
			r.v_top = 10'(band * step);
			r.last = (c == GRID_CELLS - 1);
			extents_q.push_back(r);
		end
		clear_band_extents();
	endtask

	task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	task automatic check_extent(input result_t got);
		result_t want;
		if (extents_q.size() == 0) begin
			$error("result beat with no extent pending (char_index %0d)", got.char_index);
			fail_count++;
		end else begin
			want = extents_q.pop_front();
			cmp_field("char_index", want.char_index, got.char_index);
			cmp_field("empty_cell", want.empty_cell, got.empty_cell);
			cmp_field("left_blank", want.left_blank, got.left_blank);
			cmp_field("glyph_width", want.glyph_width, got.glyph_width);
			cmp_field("glyph_height", want.glyph_height, got.glyph_height);
			cmp_field("u_left", want.u_left, got.u_left);
			cmp_field("v_top", want.v_top, got.v_top);
			cmp_field("last", want.last, got.last);
			extent_count++;
		end
	endtask

	// Watch both channels and the register port at each edge
	always @(posedge clk) begin
		if (!arst_n) begin
			model_tex_width = TEX_WIDTH_RST;
			restart_scan();
		end else begin
			if (res_if.valid && res_if.ready)
				check_extent(res_if.data);
			if (cfg_we) begin
				model_tex_width = cfg_wdata;
				restart_scan();
			end
			if (pix_if.valid && pix_if.ready) begin
				pixel_count++;
				scan_pixel(pix_if.data);
			end
		end
	end

	// Result side: random stalls, plus a long hold-off on request
	initial begin
		res_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_len != 0) begin
				res_if.ready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
			end
			res_if.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Offer one pixel beat, with random idle cycles first, and wait for it to go in
	task automatic send_pixel(input logic [7:0] a, input logic fs);
		pixel_t p;
		p.alpha = a;
		p.frame_start = fs;
		while ($urandom_range(99) < idle_pct) begin
			pix_if.valid <= 1'b0;
			@(posedge clk);
		end
		pix_if.valid <= 1'b1;
		pix_if.data <= p;
		do
			@(posedge clk);
		while (pix_if.ready !== 1'b1);
	endtask

	task automatic random_pixels(input int unsigned n, input int unsigned ink_pct,
			input int unsigned fs_pct);
		logic [7:0] a;
		for (int unsigned i = 0; i < n; i++) begin
			a = ($urandom_range(99) < ink_pct) ? 8'($urandom_range(255, 1)) : 8'h00;
			send_pixel(a, $urandom_range(99) < fs_pct);
		end
	endtask

	// One whole band; the layout of each cell rotates with shift
	task automatic send_band(input int unsigned step, input int unsigned shift, input logic mark);
		int unsigned span;
		int unsigned col;
		int unsigned row;
		int unsigned cx;
		int unsigned off;
		int unsigned sparse_pct;
		cell_pat_e kind;
		logic [7:0] a;
		span = GRID_CELLS * step;
		sparse_pct = (step > 8) ? 2 : 35;
		for (int unsigned i = 0; i < span * step; i++) begin
			col = i % span;
			row = i / span;
			cx = col / step;
			off = col % step;
			kind = cell_pat_e'((cx + shift) % N_PATTERNS);
			a = 8'h00;
			case (kind)
				PAT_LEFT: begin
					if (off == 0 && row == step / 2)
						a = 8'hFF;
				end
				PAT_RIGHT: begin
					if (off == step - 1 && row == 0)
						a = 8'h01;
				end
				PAT_BOTH: begin
					if ((off == 0 && row == step - 1) || (off == step - 1 && row == 0))
						a = 8'($urandom_range(255, 1));
				end
				PAT_SPARSE: begin
					if ($urandom_range(99) < sparse_pct)
						a = 8'($urandom_range(255, 1));
				end
				default: ;
			endcase
			send_pixel(a, mark && i == 0);
		end
	endtask

	// Drop valid and hold until every pending extent has been seen
	task automatic wait_drain();
		pix_if.valid <= 1'b0;
		@(posedge clk);
		while (extents_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_tex_width(input logic [TEX_WIDTH_W-1:0] w);
		wait_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_step = side_for(w) / GRID_CELLS;
		width_writes++;
	endtask

	// A few pixels at the reset side; the next write drops them
	task automatic test_reset_width();
		cur_step = side_for(TEX_WIDTH_RST) / GRID_CELLS;
		random_pixels(3, 50, 0);
		wait_drain();
	endtask

	// Smallest side, clamping at both ends, rounding down
	task automatic test_width_extremes();
		set_tex_width(11'd16);
		send_band(cur_step, 1, 1'b0);
		// widest sides take only a few pixels, dropped by the following write
		set_tex_width(11'd1024);
		random_pixels(2, 50, 0);
		set_tex_width(11'd2047);
		random_pixels(2, 50, 0);
		set_tex_width(11'd0);
		send_band(cur_step, 0, 1'b0);
		set_tex_width(11'd40);
		send_band(cur_step, 2, 1'b0);
		wait_drain();
	endtask

	// Frame start in mid band drops the partial band
	task automatic test_frame_restart();
		set_tex_width(11'd17);
		random_pixels(6, 40, 0);
		send_band(cur_step, 1, 1'b1);
		wait_drain();
	endtask

	// A register write in mid band drops the partial band
	task automatic test_write_discards();
		set_tex_width(11'd24);
		random_pixels(5, 40, 0);
		set_tex_width(11'd24);
		send_band(cur_step, 3, 1'b0);
		wait_drain();
	endtask

	// Hold results off while pixels keep coming, so the input stalls
	task automatic test_backpressure();
		hold_len = 300;
		random_pixels(32, 40, 0);
		wait_drain();
	endtask

	task automatic run_random_phase(input int unsigned idle, input int unsigned stall,
			input int unsigned w_lo, input int unsigned w_hi, input int unsigned n);
		int unsigned start;
		int unsigned pick;
		set_tex_width(11'($urandom_range(w_hi, w_lo)));
		idle_pct = idle;
		stall_pct = stall;
		start = pixel_count;
		while (pixel_count - start < n) begin
			pick = $urandom_range(9);
			// mostly whole bands, then broken tails and frame-start noise
			if (pick < 7)
				send_band(cur_step, $urandom_range(N_PATTERNS - 1), 1'b0);
			else if (pick < 9)
				random_pixels($urandom_range(20, 1), 30, 0);
			else
				random_pixels($urandom_range(10, 1), 30, 40);
		end
		wait_drain();
		idle_pct = 0;
		stall_pct = 0;
	endtask

	task automatic test_random_phases();
		run_random_phase(0, 0, 0, 31, 20);
		run_random_phase(73, 0, 16, 31, 20);
		run_random_phase(0, 73, 0, 31, 20);
		run_random_phase(19, 19, 0, 31, 20);
	endtask

	initial begin
		int unsigned k;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		pix_if.valid <= 1'b0;
		pix_if.data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_width();
		test_width_extremes();
		test_frame_restart();
		test_write_discards();
		test_backpressure();
		test_random_phases();

		// Let the tail drain, bounded, then look for stragglers
		for (k = 0; k < 20000 && extents_q.size() != 0; k++)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (extents_q.size() != 0) begin
			$error("%0d glyph extents never arrived", extents_q.size());
			fail_count++;
		end

		$display("Scanned %0d pixels over %0d tex_width writes (sides 16 and 32, clamped, rounded).",
			pixel_count, width_writes);
		$display("Checked %0d glyph extent beats under four idle/stall mixes and a long hold-off.",
			extent_count);
		if (fail_count == 0)
			$display("** font_atlas_glyph_extent_scan: PASSED **");
		else
			$display("** font_atlas_glyph_extent_scan: FAILED **");
		$finish;
	end

	// Watchdog
	initial begin
		#1_000_000;
		$display("** font_atlas_glyph_extent_scan: FAILED **");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/fages_pkg.sv
rtl/core/fages_stream_if.sv
rtl/core/fages_dp.sv
rtl/core/fages_ctrl.sv
rtl/core/font_atlas_glyph_extent_scan.sv
verif/tb.sv
